@@ src/olc_pkg.sv @@
package olc_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int MAX_ROUNDS     = 8;
    localparam int ROUND_BITS     = 4;
    localparam int CFG_IDX_BITS   = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_LEFT   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOTTOM = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOP    = 2'd3;

    localparam int LEFT_RST   = 0;
    localparam int RIGHT_RST  = 639;
    localparam int BOTTOM_RST = 0;
    localparam int TOP_RST    = 479;

    typedef struct packed {
        logic load;
        logic setup;
        logic mul_step;
        logic div_step;
        logic update;
        logic out_load;
        logic out_acc;
    } t_dp_cmd;

    typedef struct packed {
        logic both_in;
        logic shared;
    } t_dp_sts;

endpackage

@@ src/olc_ctrl.sv @@
module olc_ctrl #(
    parameter int COORD_BITS = olc_pkg::COORD_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    input  olc_pkg::t_dp_sts i_sts,
    output olc_pkg::t_dp_cmd o_cmd
);

    localparam int CW = $clog2(2 * COORD_BITS + 2);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;

    localparam logic [CW-1:0] MUL_LAST = CW'(COORD_BITS);
    localparam logic [CW-1:0] DIV_LAST = CW'(2 * COORD_BITS + 1);
    localparam logic [olc_pkg::ROUND_BITS-1:0] ROUND_LIM =
        olc_pkg::ROUND_BITS'(olc_pkg::MAX_ROUNDS);

    logic [2:0]                       r_state, n_state;
    logic [CW-1:0]                    r_cnt, n_cnt;
    logic [olc_pkg::ROUND_BITS-1:0]   r_round, n_round;
    logic                             r_out_valid, n_out_valid;
    logic                             out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_round     = r_round;
        n_out_valid = r_out_valid && !i_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_round    = '0;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.both_in || i_sts.shared || r_round == ROUND_LIM) begin
                    // finish only once the output register is free
                    if (out_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_acc  = i_sts.both_in;
                        n_out_valid    = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.setup = 1'b1;
                    n_cnt       = '0;
                    n_state     = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == MUL_LAST) begin
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_round      = r_round + 1'b1;
                n_state      = S_EVAL;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_div_to_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == DIV_LAST) |=> (r_state == S_UPD))
        else $error("division did not end in update");
    a_round_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_round <= ROUND_LIM))
        else $error("round count beyond limit");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_ready))
        else $error("result overwrote a waiting item");
    a_mul_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_cnt == MUL_LAST) |=> (r_state == S_DIV))
        else $error("multiply did not hand over to division");
`endif

endmodule

@@ src/olc_dp.sv @@
module olc_dp #(
    parameter int COORD_BITS = olc_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [olc_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [COORD_BITS-1:0]                i_cfg_data,
    input  logic signed [COORD_BITS-1:0]         i_start_x,
    input  logic signed [COORD_BITS-1:0]         i_start_y,
    input  logic signed [COORD_BITS-1:0]         i_end_x,
    input  logic signed [COORD_BITS-1:0]         i_end_y,
    input  olc_pkg::t_dp_cmd                     i_cmd,
    output olc_pkg::t_dp_sts                     o_sts,
    output logic signed [COORD_BITS-1:0]         o_clip_start_x,
    output logic signed [COORD_BITS-1:0]         o_clip_start_y,
    output logic signed [COORD_BITS-1:0]         o_clip_end_x,
    output logic signed [COORD_BITS-1:0]         o_clip_end_y,
    output logic                                 o_accepted
);

    localparam int W = COORD_BITS;
    localparam int P = 2 * W + 2;

    logic signed [W-1:0] r_left, r_right, r_bottom, r_top;
    logic signed [W-1:0] r_x1, r_y1, r_x2, r_y2;
    logic signed [W-1:0] r_edge, r_base;
    logic                r_xaxis, r_side, r_neg, r_zero;
    logic [W:0]          r_mcand, r_mpl, r_den, r_rem;
    logic [P-1:0]        r_quo;
    logic signed [W-1:0] r_ox1, r_oy1, r_ox2, r_oy2;
    logic                r_oacc;

    logic [3:0]          c1, c2, csel;
    logic signed [W-1:0] e_sel;
    logic [W:0]          num, fac, den;
    logic [W:0]          rem_sh_lo;
    logic [W+1:0]        rem_sh;
    logic                ge;
    logic [W-1:0]        q_lo;
    logic signed [W-1:0] newv;

    function automatic logic [3:0] outcode(
        input logic signed [W-1:0] x,
        input logic signed [W-1:0] y,
        input logic signed [W-1:0] l,
        input logic signed [W-1:0] r,
        input logic signed [W-1:0] b,
        input logic signed [W-1:0] t
    );
        logic [3:0] c;
        c    = '0;
        c[0] = (x < l);
        c[1] = (x > r);
        c[2] = (y < b);
        c[3] = (y > t);
        return c;
    endfunction

    function automatic logic [W:0] diff(
        input logic signed [W-1:0] a,
        input logic signed [W-1:0] b
    );
        return {a[W-1], a} - {b[W-1], b};
    endfunction

    function automatic logic [W:0] mag(input logic [W:0] v);
        return v[W] ? (~v + 1'b1) : v;
    endfunction

    assign c1 = outcode(r_x1, r_y1, r_left, r_right, r_bottom, r_top);
    assign c2 = outcode(r_x2, r_y2, r_left, r_right, r_bottom, r_top);
    assign o_sts.both_in = (c1 == 4'd0) && (c2 == 4'd0);
    assign o_sts.shared  = ((c1 & c2) != 4'd0);

    // the first endpoint is moved while it lies outside
    assign csel  = (c1 != 4'd0) ? c1 : c2;
    assign e_sel = csel[0] ? r_left : csel[1] ? r_right : csel[2] ? r_bottom : r_top;

    always_comb begin
        if (csel[0] || csel[1]) begin
            num = diff(r_y2, r_y1);
            fac = diff(e_sel, r_x1);
            den = diff(r_x2, r_x1);
        end else begin
            num = diff(r_x2, r_x1);
            fac = diff(e_sel, r_y1);
            den = diff(r_y2, r_y1);
        end
    end

    // restoring division, one quotient bit a cycle
    assign rem_sh_lo = r_rem;
    assign rem_sh    = {rem_sh_lo, r_quo[P-1]};
    assign ge        = (rem_sh >= {1'b0, r_den});

    assign q_lo = r_quo[W-1:0];
    assign newv = r_zero ? r_base : (r_neg ? r_base - $signed(q_lo) : r_base + $signed(q_lo));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= W'(olc_pkg::LEFT_RST);
            r_right  <= W'(olc_pkg::RIGHT_RST);
            r_bottom <= W'(olc_pkg::BOTTOM_RST);
            r_top    <= W'(olc_pkg::TOP_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                olc_pkg::REG_LEFT:   r_left   <= i_cfg_data;
                olc_pkg::REG_RIGHT:  r_right  <= i_cfg_data;
                olc_pkg::REG_BOTTOM: r_bottom <= i_cfg_data;
                olc_pkg::REG_TOP:    r_top    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x1 <= i_start_x;
            r_y1 <= i_start_y;
            r_x2 <= i_end_x;
            r_y2 <= i_end_y;
        end
        if (i_cmd.setup) begin
            r_edge  <= e_sel;
            r_base  <= (csel[0] || csel[1]) ? r_y1 : r_x1;
            r_xaxis <= csel[0] || csel[1];
            r_side  <= (c1 != 4'd0);
            r_neg   <= num[W] ^ fac[W] ^ den[W];
            r_zero  <= (num == '0) || (fac == '0) || (den == '0);
            r_mcand <= mag(num);
            r_mpl   <= mag(fac);
            r_den   <= mag(den);
            r_quo   <= '0;
            r_rem   <= '0;
        end
        if (i_cmd.mul_step) begin
            // shift-add from the top bit of the multiplier
            r_quo <= {r_quo[P-2:0], 1'b0} + (r_mpl[W] ? P'(r_mcand) : P'(0));
            r_mpl <= {r_mpl[W-1:0], 1'b0};
        end
        if (i_cmd.div_step) begin
            r_rem <= ge ? (W+1)'(rem_sh - {1'b0, r_den}) : rem_sh[W:0];
            r_quo <= {r_quo[P-2:0], ge};
        end
        if (i_cmd.update) begin
            if (r_side) begin
                r_x1 <= r_xaxis ? r_edge : newv;
                r_y1 <= r_xaxis ? newv : r_edge;
            end else begin
                r_x2 <= r_xaxis ? r_edge : newv;
                r_y2 <= r_xaxis ? newv : r_edge;
            end
        end
        if (i_cmd.out_load) begin
            r_ox1  <= r_x1;
            r_oy1  <= r_y1;
            r_ox2  <= r_x2;
            r_oy2  <= r_y2;
            r_oacc <= i_cmd.out_acc;
        end
    end

    assign o_clip_start_x = r_ox1;
    assign o_clip_start_y = r_oy1;
    assign o_clip_end_x   = r_ox2;
    assign o_clip_end_y   = r_oy2;
    assign o_accepted     = r_oacc;

endmodule

@@ src/outcode_line_clipper_top.sv @@
// channel  | handshake           | payload
// input    | i_valid / o_ready   | i_start_x, i_start_y, i_end_x, i_end_y
// output   | o_valid / i_ready   | o_clip_start_x/y, o_clip_end_x/y, o_accepted
// config   | i_cfg_we            | i_cfg_idx, i_cfg_data
// one item at a time; each clip round runs a setup step, a shift-add multiply, a restoring
// divide and an update, the multiply and divide sharing one shift-add/restoring unit
// rounds are at most four on real segments and never more than eight
// synchronous active-low reset restores the window to 0..639 by 0..479
// a waiting result holds the last decision until the output register is free
module outcode_line_clipper_top #(
    parameter int COORD_BITS = olc_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [olc_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [COORD_BITS-1:0]             i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [COORD_BITS-1:0]      i_start_x,
    input  logic signed [COORD_BITS-1:0]      i_start_y,
    input  logic signed [COORD_BITS-1:0]      i_end_x,
    input  logic signed [COORD_BITS-1:0]      i_end_y,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [COORD_BITS-1:0]      o_clip_start_x,
    output logic signed [COORD_BITS-1:0]      o_clip_start_y,
    output logic signed [COORD_BITS-1:0]      o_clip_end_x,
    output logic signed [COORD_BITS-1:0]      o_clip_end_y,
    output logic                              o_accepted
);

    olc_pkg::t_dp_cmd cmd;
    olc_pkg::t_dp_sts sts;

    olc_ctrl #(.COORD_BITS(COORD_BITS)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    olc_dp #(.COORD_BITS(COORD_BITS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_clip_start_x (o_clip_start_x),
        .o_clip_start_y (o_clip_start_y),
        .o_clip_end_x   (o_clip_end_x),
        .o_clip_end_y   (o_clip_end_y),
        .o_accepted     (o_accepted)
    );

endmodule
